// ----- src/cea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cea_pkg: shared types and constants
// Register map, button status codes and field widths for the click encoder.
// ----------------------------------------------------------------------------
package cea_pkg;

  localparam int unsigned STEP_W    = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  // Register reset values
  localparam logic [14:0] ACCEL_TOP_RST       = 15'd3072;
  localparam logic [9:0]  ACCEL_INC_RST       = 10'd25;
  localparam logic [9:0]  ACCEL_DECAY_RST     = 10'd2;
  localparam logic [7:0]  BUTTON_INTERVAL_RST = 8'd10;
  localparam logic [7:0]  DOUBLE_CHECKS_RST   = 8'd60;
  localparam logic [15:0] HOLD_CHECKS_RST     = 16'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_TOP       = 3'd0,
    CFG_ACCEL_INC       = 3'd1,
    CFG_ACCEL_DECAY     = 3'd2,
    CFG_BUTTON_INTERVAL = 3'd3,
    CFG_DOUBLE_CHECKS   = 3'd4,
    CFG_HOLD_CHECKS     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OPEN     = 3'd0,
    ST_CLICKED  = 3'd1,
    ST_DOUBLE   = 3'd2,
    ST_HELD     = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef struct packed {
    logic [14:0] accel_top;
    logic [9:0]  accel_inc;
    logic [9:0]  accel_decay;
    logic [7:0]  button_interval;
    logic [7:0]  double_checks;
    logic [15:0] hold_checks;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/click_encoder_with_acceleration.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// click_encoder_with_acceleration: rotary encoder and button decoder
// Top level: config registers, input register, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction is one sample tick carrying encoder phases,
//   the button level and the two read strobes. Every tick yields exactly one
//   master-side transaction with the step value and button status.
//   A tick is registered in the input register, processed and its result
//   registered in the result register once the output is free; m_axis_tvalid is then high.
//   Throughput: one tick per cycle unless the receiver stalls, limited by the single
//   pass from the input register through the decode logic into the result register.
//   When the receiver stalls, the result holds and one more tick waits in the
//   input register; s_axis_tready drops only once both are full.
//   Reset clears all control state and loads default register values; the first tick
//   after reset only captures the encoder phase. The config port writes a
//   register at any edge with cfg_we_i high and is meant for idle periods.
// ----------------------------------------------------------------------------
module click_encoder_with_acceleration (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // config port
  input  wire                             cfg_we_i,
  input  wire [cea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [cea_pkg::CFG_W-1:0]        cfg_data_i,
  // tick stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // pin_a_low, pin_b_low, button_low, read_value, read_button, 3'b0
  input  wire [7:0]                       s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // step_value[8:0], button_status[11:9], 4'b0
  output logic [15:0]                     m_axis_tdata
);

  cea_pkg::cfg_t cfg_q;
  logic          in_valid_q;
  logic [4:0]    in_data_q;
  logic          out_valid_q;
  logic [11:0]   out_data_q;
  logic          advance;
  logic          primed;
  logic signed [cea_pkg::STEP_W-1:0] step;
  cea_pkg::status_e status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_top       <= cea_pkg::ACCEL_TOP_RST;
      cfg_q.accel_inc       <= cea_pkg::ACCEL_INC_RST;
      cfg_q.accel_decay     <= cea_pkg::ACCEL_DECAY_RST;
      cfg_q.button_interval <= cea_pkg::BUTTON_INTERVAL_RST;
      cfg_q.double_checks   <= cea_pkg::DOUBLE_CHECKS_RST;
      cfg_q.hold_checks     <= cea_pkg::HOLD_CHECKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cea_pkg::CFG_ACCEL_TOP:       cfg_q.accel_top       <= cfg_data_i[14:0];
        cea_pkg::CFG_ACCEL_INC:       cfg_q.accel_inc       <= cfg_data_i[9:0];
        cea_pkg::CFG_ACCEL_DECAY:     cfg_q.accel_decay     <= cfg_data_i[9:0];
        cea_pkg::CFG_BUTTON_INTERVAL: cfg_q.button_interval <= cfg_data_i[7:0];
        cea_pkg::CFG_DOUBLE_CHECKS:   cfg_q.double_checks   <= cfg_data_i[7:0];
        cea_pkg::CFG_HOLD_CHECKS:     cfg_q.hold_checks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[4:0];
    end
  end

  cea_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .pin_a_i  (in_data_q[0]),
    .pin_b_i  (in_data_q[1]),
    .read_i   (in_data_q[3]),
    .cfg_i    (cfg_q),
    .primed_o (primed),
    .step_o   (step)
  );

  cea_button u_button (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .primed_i (primed),
    .button_i (in_data_q[2]),
    .read_i   (in_data_q[4]),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {status, step};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready) else $error("input register empty but not ready");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance)) else $error("result without a tick");

endmodule
`default_nettype wire

// ----- src/cea_motion.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cea_motion: quadrature decode and acceleration
// Tracks phase, movement count and decaying acceleration; forms the step.
// ----------------------------------------------------------------------------
module cea_motion (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              pin_a_i,
  input  wire                              pin_b_i,
  input  wire                              read_i,
  input  wire cea_pkg::cfg_t               cfg_i,
  output logic                             primed_o,
  output logic signed [cea_pkg::STEP_W-1:0] step_o
);

  logic [1:0]  phase_q, phase_d, now_phase, diff;
  logic        primed_q;
  logic [15:0] delta_q, delta_d, delta_t;
  logic [15:0] acc_q, acc_d, acc_dec;
  logic [16:0] acc_sum;
  logic [8:0]  mag;

  // phase code: A gives 3, B toggles bit 0
  assign now_phase = {pin_a_i, pin_a_i ^ pin_b_i};
  assign diff      = phase_q - now_phase;
  assign acc_dec   = (acc_q < {6'd0, cfg_i.accel_decay}) ? 16'd0
                   : acc_q - {6'd0, cfg_i.accel_decay};
  assign acc_sum   = {1'b0, acc_dec} + {7'd0, cfg_i.accel_inc};

  always_comb begin
    phase_d = phase_q;
    delta_t = delta_q;
    acc_d   = acc_q;
    if (!primed_q) begin
      phase_d = now_phase;
    end else begin
      acc_d = acc_dec;
      if (diff[0]) begin
        phase_d = now_phase;
        delta_t = diff[1] ? delta_q + 16'd1 : delta_q - 16'd1;
        if (acc_sum <= {2'd0, cfg_i.accel_top}) begin
          acc_d = acc_sum[15:0];
        end
      end
    end
    delta_d = read_i ? {15'd0, delta_t[0]} : delta_t;
  end

  assign mag = {1'b0, acc_d[15:8]} + 9'd1;

  always_comb begin
    step_o = '0;
    if (read_i) begin
      if (delta_t[15]) begin
        step_o = -mag;
      end else if (delta_t[15:1] != 15'd0) begin
        step_o = mag;
      end
    end
  end

  assign primed_o = primed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      phase_q  <= '0;
      delta_q  <= '0;
      acc_q    <= '0;
    end else if (en_i) begin
      primed_q <= 1'b1;
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      acc_q    <= acc_d;
    end
  end

  // growth is bounded by a 15-bit ceiling
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q[15] == 1'b0) else $error("acceleration exceeded 15 bits");

  a_unprimed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> (delta_q == 16'd0 && acc_q == 16'd0))
    else $error("movement before first tick");

endmodule
`default_nettype wire

// ----- src/cea_button.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cea_button: button classifier
// Periodic checks for click, double click, hold and release; status read.
// ----------------------------------------------------------------------------
module cea_button (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    primed_i,
  input  wire                    button_i,
  input  wire                    read_i,
  input  wire cea_pkg::cfg_t     cfg_i,
  output cea_pkg::status_e       status_o
);

  cea_pkg::status_e status_q, status_d, st_v;
  logic [15:0] pressed_q, pressed_d, pc_inc;
  logic [7:0]  window_q, window_d, cw_v;
  logic [7:0]  interval_q, interval_d, ic_inc;
  logic        check;

  assign ic_inc = interval_q + 8'd1;
  assign check  = primed_i && (ic_inc >= cfg_i.button_interval);
  assign pc_inc = (pressed_q == 16'hFFFF) ? pressed_q : pressed_q + 16'd1;

  always_comb begin
    st_v       = status_q;
    cw_v       = window_q;
    pressed_d  = pressed_q;
    interval_d = primed_i ? ic_inc : interval_q;
    if (check) begin
      interval_d = '0;
      if (button_i) begin
        pressed_d = pc_inc;
        if (pc_inc > cfg_i.hold_checks) begin
          st_v = cea_pkg::ST_HELD;
        end
      end else begin
        if (pressed_q != 16'd0) begin
          if (status_q == cea_pkg::ST_HELD) begin
            st_v = cea_pkg::ST_RELEASED;
            cw_v = '0;
          end else if (window_q > 8'd1) begin
            if (window_q < cfg_i.double_checks) begin
              st_v = cea_pkg::ST_DOUBLE;
              cw_v = '0;
            end
          end else begin
            cw_v = cfg_i.double_checks;
          end
        end
        pressed_d = '0;
      end
      // countdown by two, saturating; expiry means a single click
      if (cw_v != 8'd0) begin
        cw_v = (cw_v >= 8'd2) ? cw_v - 8'd2 : 8'd0;
        if (cw_v == 8'd0) begin
          st_v = cea_pkg::ST_CLICKED;
        end
      end
    end
    window_d = cw_v;
    status_d = st_v;
    status_o = cea_pkg::ST_OPEN;
    if (read_i) begin
      status_o = st_v;
      if (st_v != cea_pkg::ST_HELD) begin
        status_d = cea_pkg::ST_OPEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= cea_pkg::ST_OPEN;
      pressed_q  <= '0;
      window_q   <= '0;
      interval_q <= '0;
    end else if (en_i) begin
      status_q   <= status_d;
      pressed_q  <= pressed_d;
      window_q   <= window_d;
      interval_q <= interval_d;
    end
  end

  // held is only entered while pressed and left on the release check
  a_held_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == cea_pkg::ST_HELD |-> pressed_q != 16'd0)
    else $error("held status without pressed count");

  a_no_check_unprimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_i |-> (interval_q == 8'd0 && pressed_q == 16'd0))
    else $error("button check before first tick");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for click_encoder_with_acceleration
// Streams encoder/button sample ticks into the block with and without random backpressure
// and checks every result against a cycle-free behavioral predictor. Covers
// quadrature walks with glitches, click/double-click/hold/release sequences,
// and several register settings including their extremes.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_TICKS    = 240;
  localparam int unsigned NUM_SETTINGS   = 6;
  // indexes past the register list, must be ignored
  localparam logic [cea_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [cea_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [8:0]       step;
    cea_pkg::status_e status;
  } tick_result_t;

  // Behavioral predictor plus the queue of results still owed by the block.
  class encoder_scoreboard;
    logic [14:0]  accel_top;
    logic [9:0]   accel_inc;
    logic [9:0]   accel_decay;
    logic [7:0]   interval;
    logic [7:0]   dbl_checks;
    logic [15:0]  hold_checks;

    logic [1:0]       last_phase;
    bit               primed;
    logic [15:0]      delta;
    logic [15:0]      accel;
    cea_pkg::status_e status;
    logic [15:0]      press_cnt;
    logic [7:0]       window;
    logic [7:0]       interval_cnt;

    tick_result_t owed_results[$];
    int unsigned  errors;

    function new();
      accel_top    = cea_pkg::ACCEL_TOP_RST;
      accel_inc    = cea_pkg::ACCEL_INC_RST;
      accel_decay  = cea_pkg::ACCEL_DECAY_RST;
      interval     = cea_pkg::BUTTON_INTERVAL_RST;
      dbl_checks   = cea_pkg::DOUBLE_CHECKS_RST;
      hold_checks  = cea_pkg::HOLD_CHECKS_RST;
      last_phase   = '0;
      primed       = 1'b0;
      delta        = '0;
      accel        = '0;
      status       = cea_pkg::ST_OPEN;
      press_cnt    = '0;
      window       = '0;
      interval_cnt = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [cea_pkg::CFG_IDX_W-1:0] idx,
                            logic [cea_pkg::CFG_W-1:0] val);
      case (idx)
        cea_pkg::CFG_ACCEL_TOP:       accel_top   = val[14:0];
        cea_pkg::CFG_ACCEL_INC:       accel_inc   = val[9:0];
        cea_pkg::CFG_ACCEL_DECAY:     accel_decay = val[9:0];
        cea_pkg::CFG_BUTTON_INTERVAL: interval    = val[7:0];
        cea_pkg::CFG_DOUBLE_CHECKS:   dbl_checks  = val[7:0];
        cea_pkg::CFG_HOLD_CHECKS:     hold_checks = val[15:0];
        default: ;
      endcase
    endfunction

    function void classify_button(bit pressed);
      if (pressed) begin
        if (press_cnt != 16'hFFFF) press_cnt = press_cnt + 16'd1;
        if (press_cnt > hold_checks) status = cea_pkg::ST_HELD;
      end else begin
        if (press_cnt != 0) begin
          if (status == cea_pkg::ST_HELD) begin
            status = cea_pkg::ST_RELEASED;
            window = '0;
          end else if (window > 8'd1) begin
            if (window < dbl_checks) begin
              status = cea_pkg::ST_DOUBLE;
              window = '0;
            end
          end else begin
            window = dbl_checks;
          end
        end
        press_cnt = '0;
      end
      // countdown moves by two, saturating; hitting zero reports a click
      if (window > 0) begin
        window = (window >= 8'd2) ? window - 8'd2 : 8'd0;
        if (window == 0) status = cea_pkg::ST_CLICKED;
      end
    endfunction

    // fields: {read_button, read_value, button_low, pin_b_low, pin_a_low}
    function void take_tick(logic [4:0] f);
      logic [1:0]   now_ph;
      logic [1:0]   diff;
      logic [15:0]  old;
      logic [8:0]   mag;
      tick_result_t r;
      now_ph   = {f[0], f[0] ^ f[1]};
      r.step   = '0;
      r.status = cea_pkg::ST_OPEN;
      if (!primed) begin
        last_phase = now_ph;
        primed     = 1'b1;
      end else begin
        accel = (accel < 16'(accel_decay)) ? 16'd0 : accel - 16'(accel_decay);
        diff  = last_phase - now_ph;
        if (diff[0]) begin
          last_phase = now_ph;
          delta      = diff[1] ? delta + 16'd1 : delta - 16'd1;
          if (32'(accel) + 32'(accel_inc) <= 32'(accel_top))
            accel = accel + 16'(accel_inc);
        end
        interval_cnt = interval_cnt + 8'd1;
        if (interval_cnt >= interval) begin
          interval_cnt = '0;
          classify_button(f[2]);
        end
      end
      if (f[3]) begin
        old   = delta;
        delta = {15'd0, old[0]};
        mag   = 9'd1 + 9'(accel >> 8);
        if (old[15]) r.step = 9'd0 - mag;
        else if (old[15:1] != 0) r.step = mag;
      end
      if (f[4]) begin
        r.status = status;
        if (status != cea_pkg::ST_HELD) status = cea_pkg::ST_OPEN;
      end
      owed_results.push_back(r);
    endfunction

    function void match_result(logic [15:0] d);
      tick_result_t e;
      if (owed_results.size() == 0) begin
        $error("result with no tick outstanding: tdata=%h", d);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (d[8:0] !== e.step) begin
        $error("step_value: expected %0d, actual %0d", $signed(e.step), $signed(d[8:0]));
        errors++;
      end
      if (d[11:9] !== e.status) begin
        $error("button_status: expected %0d, actual %0d", e.status, d[11:9]);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [cea_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [cea_pkg::CFG_W-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;

  encoder_scoreboard sb;
  int unsigned src_idle_pct = 23;
  int unsigned snk_idle_pct = 76;
  int unsigned tick_count   = 0;
  int unsigned result_count = 0;

  // random walk state
  logic [1:0]  enc_pos   = 2'd0;
  bit          enc_fwd   = 1'b1;
  logic        btn_level = 1'b0;
  int unsigned btn_left  = 0;

  click_encoder_with_acceleration uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // transaction monitor: both sides sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.take_tick(s_axis_tdata[4:0]);
      tick_count++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.match_result(m_axis_tdata);
      result_count++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_tick(input logic [4:0] fields);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, fields};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [cea_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cea_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // stop sending and drain all owed results, then let the pipeline idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // unused upper data bits are randomized to exercise register masking
  task automatic load_setting(input cea_pkg::cfg_t c);
    write_reg(cea_pkg::CFG_ACCEL_TOP,       {1'($urandom), c.accel_top});
    write_reg(cea_pkg::CFG_ACCEL_INC,       {6'($urandom), c.accel_inc});
    write_reg(cea_pkg::CFG_ACCEL_DECAY,     {6'($urandom), c.accel_decay});
    write_reg(cea_pkg::CFG_BUTTON_INTERVAL, {8'($urandom), c.button_interval});
    write_reg(cea_pkg::CFG_DOUBLE_CHECKS,   {8'($urandom), c.double_checks});
    write_reg(cea_pkg::CFG_HOLD_CHECKS,     c.hold_checks);
  endtask

  // packed order: accel_top, accel_inc, accel_decay, interval, double_checks, hold
  function automatic cea_pkg::cfg_t setting_for(int unsigned n);
    case (n)
      0: return {15'd2000, 10'd200, 10'd3, 8'd3, 8'd8, 16'd5};
      1: return {15'd32767, 10'd1023, 10'd0, 8'd1, 8'd4, 16'd3};
      2: return {15'd0, 10'd0, 10'd1023, 8'd2, 8'd254, 16'd65534};
      3: return {15'd100, 10'd30, 10'd5, 8'd0, 8'd3, 16'd1};
      4: return {15'($urandom), 10'($urandom), 10'($urandom_range(0, 40)), 8'd255,
                 8'($urandom_range(2, 16)), 16'($urandom_range(1, 12))};
      default: return {15'($urandom), 10'($urandom), 10'($urandom_range(0, 40)),
                       8'($urandom_range(1, 4)), 8'($urandom_range(2, 16)),
                       16'($urandom_range(1, 12))};
    endcase
  endfunction

  function automatic logic [4:0] tick_fields(logic [1:0] pos, logic btn, logic rv, logic rb);
    return {rb, rv, btn, pos[1] ^ pos[0], pos[1]};
  endfunction

  // press/release run lengths sized to the current interval, so that clicks,
  // double clicks, holds and releases all show up
  function automatic int unsigned button_run(logic pressed);
    int unsigned unit;
    int unsigned hold_len;
    int unsigned gap_len;
    unit = (sb.interval == 0) ? 1 : sb.interval;
    if (pressed) begin
      hold_len = unit * (sb.hold_checks + 2);
      if ($urandom_range(0, 3) == 0 && hold_len <= 300)
        return hold_len + $urandom_range(0, 2 * unit);
      return unit * $urandom_range(1, 3) + $urandom_range(0, unit - 1);
    end
    gap_len = unit * (sb.dbl_checks / 2 + 1);
    if ($urandom_range(0, 1) == 0 && gap_len <= 300)
      return gap_len + $urandom_range(0, unit);
    return unit * $urandom_range(1, 4);
  endfunction

  function automatic logic [4:0] next_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) enc_fwd = !enc_fwd;
    else if (r < 12) enc_pos = enc_pos + 2'd2;  // skipped state, no movement
    else if (r < 70) enc_pos = enc_fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
    if (btn_left == 0) begin
      btn_level = !btn_level;
      btn_left  = button_run(btn_level);
    end
    btn_left--;
    return tick_fields(enc_pos, btn_level,
                       $urandom_range(0, 99) < 25, $urandom_range(0, 99) < 30);
  endfunction

  initial begin
    logic [1:0] walk[24];
    sb   = new();
    walk = '{2, 3, 0, 1, 0, 3, 1, 1, 2, 3, 0, 1, 2, 3, 3, 2, 1, 0, 3, 2, 0, 2, 0, 1};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first tick with both reads, steps both ways, skipped states,
    // negative and zero halved movement, a short press
    for (int i = 0; i < 24; i++) begin
      send_tick(tick_fields(walk[i], i >= 5 && i < 15,
                            (i % 3 == 0) || i == 5, (i % 4 == 0) || i == 21));
    end
    enc_pos = walk[23];

    for (int unsigned n = 0; n < NUM_SETTINGS; n++) begin
      drain();
      if (n == 2) begin
        src_idle_pct = 76;
        snk_idle_pct = 23;
      end else if (n == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      load_setting(setting_for(n));
      if (n == 3) begin
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
      end
      for (int unsigned k = 0; k < PHASE_TICKS; k++) send_tick(next_tick());
    end
    drain();

    $display("Checked %0d ticks against %0d results across %0d register settings,",
             tick_count, result_count, NUM_SETTINGS + 1);
    $display("with sender-side, receiver-side and no backpressure.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
